// ----- src/json_string_unescape_unit_macros.svh -----
// Assertion macros used by the checker module.
`ifndef JSON_STRING_UNESCAPE_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UNIT_MACROS_SVH

// Checked on every edge once reset is released.
`define JSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/jsu_pkg.sv -----
`default_nettype none
package jsu_pkg;

    // front state
    typedef enum logic [2:0] {
        PH_WAIT,
        PH_BODY,
        PH_ESC,
        PH_HEX,
        PH_HEXBAD
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_DONE,
        KIND_ERR
    } kind_t;

    // error codes
    localparam logic [2:0] ERR_NO_OPEN  = 3'd0;
    localparam logic [2:0] ERR_END_ESC  = 3'd1;
    localparam logic [2:0] ERR_END_HEX  = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd4;
    localparam logic [2:0] ERR_CTRL     = 3'd5;
    localparam logic [2:0] ERR_UNTERM   = 3'd6;
    localparam logic [2:0] ERR_NONE     = 3'd0;

    // characters
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // UTF-8 encoding
    localparam logic [15:0] CP_1B_LIMIT = 16'h0080;
    localparam logic [15:0] CP_2B_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF_LEAD2   = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF_CONT    = 8'h80;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one queue entry: the one to three results caused by one input beat
    typedef struct packed {
        kind_t           kind;
        logic [2:0]      code;
        logic [1:0]      n_last;   // index of the final result
        logic [2:0][7:0] bytes;
    } cmd_t;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // {valid, byte}
    function automatic logic [8:0] simple_escape(input logic [7:0] e);
        logic [8:0] r;
        unique case (e)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/jsu_front.sv -----
`default_nettype none
module jsu_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_in_byte,
    input  wire logic          s_end_of_text,
    input  wire logic          q_full,
    output logic               push,
    output jsu_pkg::cmd_t      push_cmd
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     cp_reg, cp_next;
    logic [1:0]      hc_reg, hc_next;

    logic            accept;
    logic            emit;
    logic [4:0]      hv;
    logic [8:0]      esc;
    logic [15:0]     cp_new;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && emit;

    assign hv     = jsu_pkg::hex_value(s_in_byte);
    assign esc    = jsu_pkg::simple_escape(s_in_byte);
    assign cp_new = {cp_reg[11:0], hv[3:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= jsu_pkg::PH_WAIT;
            cp_reg    <= '0;
            hc_reg    <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cp_reg    <= cp_next;
            hc_reg    <= hc_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        cp_next         = cp_reg;
        hc_next         = hc_reg;
        emit            = 1'b0;
        push_cmd.kind   = jsu_pkg::KIND_DATA;
        push_cmd.code   = jsu_pkg::ERR_NONE;
        push_cmd.n_last = 2'd0;
        push_cmd.bytes  = '0;

        unique case (phase_reg)
            jsu_pkg::PH_BODY: begin
                if (s_end_of_text) begin
                    phase_next = jsu_pkg::PH_WAIT;
                    emit = 1'b1;
                    push_cmd.kind = jsu_pkg::KIND_ERR;
                    push_cmd.code = jsu_pkg::ERR_UNTERM;
                end else if (s_in_byte == jsu_pkg::CH_QUOTE) begin
                    phase_next = jsu_pkg::PH_WAIT;
                    emit = 1'b1;
                    push_cmd.kind = jsu_pkg::KIND_DONE;
                end else if (s_in_byte == jsu_pkg::CH_BSLASH) begin
                    phase_next = jsu_pkg::PH_ESC;
                end else if (s_in_byte < jsu_pkg::CH_SPACE) begin
                    phase_next = jsu_pkg::PH_WAIT;
                    emit = 1'b1;
                    push_cmd.kind = jsu_pkg::KIND_ERR;
                    push_cmd.code = jsu_pkg::ERR_CTRL;
                end else begin
                    emit = 1'b1;
                    push_cmd.bytes[0] = s_in_byte;
                end
            end
            jsu_pkg::PH_ESC: begin
                if (s_end_of_text) begin
                    phase_next = jsu_pkg::PH_WAIT;
                    emit = 1'b1;
                    push_cmd.kind = jsu_pkg::KIND_ERR;
                    push_cmd.code = jsu_pkg::ERR_END_ESC;
                end else if (s_in_byte == jsu_pkg::CH_U) begin
                    phase_next = jsu_pkg::PH_HEX;
                    cp_next = '0;
                    hc_next = '0;
                end else if (esc[8]) begin
                    phase_next = jsu_pkg::PH_BODY;
                    emit = 1'b1;
                    push_cmd.bytes[0] = esc[7:0];
                end else begin
                    phase_next = jsu_pkg::PH_WAIT;
                    emit = 1'b1;
                    push_cmd.kind = jsu_pkg::KIND_ERR;
                    push_cmd.code = jsu_pkg::ERR_BAD_ESC;
                end
            end
            jsu_pkg::PH_HEX: begin
                if (s_end_of_text) begin
                    phase_next = jsu_pkg::PH_WAIT;
                    emit = 1'b1;
                    push_cmd.kind = jsu_pkg::KIND_ERR;
                    push_cmd.code = jsu_pkg::ERR_END_HEX;
                end else if (!hv[4]) begin
                    if (hc_reg == 2'd3) begin
                        phase_next = jsu_pkg::PH_WAIT;
                        emit = 1'b1;
                        push_cmd.kind = jsu_pkg::KIND_ERR;
                        push_cmd.code = jsu_pkg::ERR_BAD_HEX;
                    end else begin
                        hc_next = hc_reg + 2'd1;
                        phase_next = jsu_pkg::PH_HEXBAD;
                    end
                end else begin
                    cp_next = cp_new;
                    if (hc_reg == 2'd3) begin
                        hc_next = '0;
                        phase_next = jsu_pkg::PH_BODY;
                        emit = 1'b1;
                        if (cp_new < jsu_pkg::CP_1B_LIMIT) begin
                            push_cmd.bytes[0] = cp_new[7:0];
                        end else if (cp_new < jsu_pkg::CP_2B_LIMIT) begin
                            push_cmd.n_last   = 2'd1;
                            push_cmd.bytes[0] = jsu_pkg::UTF_LEAD2 | {3'b0, cp_new[10:6]};
                            push_cmd.bytes[1] = jsu_pkg::UTF_CONT | {2'b0, cp_new[5:0]};
                        end else begin
                            push_cmd.n_last   = 2'd2;
                            push_cmd.bytes[0] = jsu_pkg::UTF_LEAD3 | {4'b0, cp_new[15:12]};
                            push_cmd.bytes[1] = jsu_pkg::UTF_CONT | {2'b0, cp_new[11:6]};
                            push_cmd.bytes[2] = jsu_pkg::UTF_CONT | {2'b0, cp_new[5:0]};
                        end
                    end else begin
                        hc_next = hc_reg + 2'd1;
                    end
                end
            end
            jsu_pkg::PH_HEXBAD: begin
                // bad digit seen: swallow the rest of the four characters
                if (s_end_of_text) begin
                    phase_next = jsu_pkg::PH_WAIT;
                    emit = 1'b1;
                    push_cmd.kind = jsu_pkg::KIND_ERR;
                    push_cmd.code = jsu_pkg::ERR_END_HEX;
                end else if (hc_reg == 2'd3) begin
                    phase_next = jsu_pkg::PH_WAIT;
                    emit = 1'b1;
                    push_cmd.kind = jsu_pkg::KIND_ERR;
                    push_cmd.code = jsu_pkg::ERR_BAD_HEX;
                end else begin
                    hc_next = hc_reg + 2'd1;
                end
            end
            default: begin
                // waiting for the opening quote
                if (s_end_of_text || s_in_byte != jsu_pkg::CH_QUOTE) begin
                    phase_next = jsu_pkg::PH_WAIT;
                    emit = 1'b1;
                    push_cmd.kind = jsu_pkg::KIND_ERR;
                    push_cmd.code = jsu_pkg::ERR_NO_OPEN;
                end else begin
                    phase_next = jsu_pkg::PH_BODY;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/jsu_queue.sv -----
`default_nettype none
module jsu_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire jsu_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output jsu_pkg::cmd_t      head
);

    jsu_pkg::cmd_t                 entry_reg [jsu_pkg::Q_DEPTH];
    logic [jsu_pkg::Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [jsu_pkg::Q_CNT_W-1:0]   count_reg;

    assign full  = count_reg == jsu_pkg::Q_CNT_W'(jsu_pkg::Q_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/jsu_back.sv -----
`default_nettype none
module jsu_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_empty,
    input  wire jsu_pkg::cmd_t head,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_out_kind,
    output logic [7:0]         m_out_byte,
    output logic [2:0]         m_error_code,
    output logic               m_last
);

    logic [1:0] sel_reg;
    logic       valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic [2:0] code_reg;
    logic       last_reg;

    logic       load;
    logic       is_last;
    logic [7:0] sel_byte;

    assign load    = !q_empty && (!valid_reg || m_ready);
    assign is_last = sel_reg == head.n_last;
    assign pop     = load && is_last;

    always_comb begin
        unique case (sel_reg)
            2'd0:    sel_byte = head.bytes[0];
            2'd1:    sel_byte = head.bytes[1];
            2'd2:    sel_byte = head.bytes[2];
            default: sel_byte = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                sel_reg   <= is_last ? 2'd0 : sel_reg + 2'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= head.kind;
            byte_reg <= sel_byte;
            code_reg <= head.code;
            last_reg <= is_last;
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_kind   = kind_reg;
    assign m_out_byte   = byte_reg;
    assign m_error_code = code_reg;
    assign m_last       = last_reg;

endmodule
`default_nettype wire

// ----- src/json_string_unescape_unit.sv -----
// Channel | Direction | Ports                                   | Handshake
// input   | in        | s_in_byte, s_end_of_text                | s_valid / s_ready
// result  | out       | m_out_kind, m_out_byte, m_error_code,   | m_valid / m_ready
//         |           | m_last                                  |
//
// One input beat is taken per cycle while the result queue has room; the front
// decodes it in that same cycle and queues the results it causes.
// The back drains one result per cycle while m_ready is high, so a \u escape that
// makes two or three UTF-8 bytes keeps the back on one entry; the queue absorbs it.
// An input beat's first result goes through the queue entry, then the output register.
// aresetn is synchronous, active low; it returns the parser to waiting for a quote.
// m_ready low only stalls the back; the front keeps going until the queue fills.
`default_nettype none
module json_string_unescape_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_end_of_text,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_out_kind,
    output logic [7:0]      m_out_byte,
    output logic [2:0]      m_error_code,
    output logic            m_last
);

    // front -> queue
    logic          push;
    jsu_pkg::cmd_t push_cmd;
    logic          q_full;

    // queue -> back
    logic          q_empty;
    logic          pop;
    jsu_pkg::cmd_t head;

    // Front: parser state (phase, code point, hex count); one beat per cycle while q_full low.
    jsu_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    // Queue: one entry per input beat that yields any result.
    jsu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    // Back: walks an entry's bytes into the output register, flags the last.
    jsu_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .head         (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_kind   (m_out_kind),
        .m_out_byte   (m_out_byte),
        .m_error_code (m_error_code),
        .m_last       (m_last)
    );

endmodule
`default_nettype wire

// ----- src/jsu_checker.sv -----
`default_nettype none
`include "json_string_unescape_unit_macros.svh"
module jsu_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_out_kind,
    input wire logic [7:0] m_out_byte,
    input wire logic [2:0] m_error_code,
    input wire logic       m_last
);

    // completion and error beats stand alone
    `JSU_ASSERT(a_ctrl_is_last, m_valid && m_out_kind != jsu_pkg::KIND_DATA |-> m_last, "done or error beat without last")

    `JSU_ASSERT(a_code_zero, m_valid && m_out_kind != jsu_pkg::KIND_ERR |-> m_error_code == 3'd0, "error code set on non-error beat")

    `JSU_ASSERT(a_byte_zero, m_valid && m_out_kind != jsu_pkg::KIND_DATA |-> m_out_byte == 8'd0, "byte set on non-data beat")

    `JSU_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result valid right after reset")

    `JSU_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last), "stalled result beat changed")

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_kind   (m_out_kind),
    .m_out_byte   (m_out_byte),
    .m_error_code (m_error_code),
    .m_last       (m_last)
);
`default_nettype wire

// ----- dv/tb_json_string_unescape_unit.sv -----
`timescale 1ns / 1ps

module tb_json_string_unescape_unit;

    // One text beat as the sender presents it.
    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } text_beat_t;

    // One decoded result as the block should emit it.
    typedef struct {
        jsu_pkg::kind_t kind;
        logic [7:0]     data;
        logic [2:0]     code;
        logic           last;
    } unescaped_t;

    // Escape letters the block accepts after a backslash: quote, backslash, slash, b f n r t.
    localparam logic [7:0] ESC_LETTERS [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62,
                                               8'h66, 8'h6E, 8'h72, 8'h74};
    localparam int RANDOM_BEATS  = 200;
    localparam int FINAL_STRETCH = 40;   // last beats go out with no idling on either side
    localparam int DRAIN_CYCLES  = 20;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte     = 8'h00;
    logic       s_end_of_text = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [1:0] m_out_kind;
    logic [7:0] m_out_byte;
    logic [2:0] m_error_code;
    logic       m_last;

    text_beat_t pending_beats[$];     // text still to be sent
    unescaped_t expected_results[$];  // decoded output still owed by the block
    unescaped_t beat_results[$];      // scratch: results of the beat being decoded
    int         fail_count = 0;

    // Parser state, mirrored from the block's point of view.
    jsu_pkg::phase_t parse_phase = jsu_pkg::PH_WAIT;
    logic [15:0]     code_point  = 16'h0000;
    logic [1:0]      hex_count   = 2'd0;

    always #5 aclk = ~aclk;

    json_string_unescape_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_kind    (m_out_kind),
        .m_out_byte    (m_out_byte),
        .m_error_code  (m_error_code),
        .m_last        (m_last)
    );

    // ------------------------------------------------------------------
    // Character helpers, shared by stimulus and prediction
    // ------------------------------------------------------------------

    // {is_hex, nibble}
    function automatic logic [4:0] nibble_of(input logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39) return {1'b1, 4'(ch - 8'h30)};
        if (ch >= 8'h61 && ch <= 8'h66) return {1'b1, 4'(ch - 8'h61 + 8'd10)};
        if (ch >= 8'h41 && ch <= 8'h46) return {1'b1, 4'(ch - 8'h41 + 8'd10)};
        return 5'd0;
    endfunction

    // {is_escape, decoded byte} for the letter after a backslash
    function automatic logic [8:0] escape_target(input logic [7:0] ch);
        case (ch)
            8'h22:   return {1'b1, 8'h22};
            8'h5C:   return {1'b1, 8'h5C};
            8'h2F:   return {1'b1, 8'h2F};
            8'h62:   return {1'b1, 8'h08};
            8'h66:   return {1'b1, 8'h0C};
            8'h6E:   return {1'b1, 8'h0A};
            8'h72:   return {1'b1, 8'h0D};
            8'h74:   return {1'b1, 8'h09};
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: decodes one accepted beat into the results it owes
    // ------------------------------------------------------------------

    function automatic void owe(input jsu_pkg::kind_t kind, input logic [7:0] data,
                                input logic [2:0] code);
        unescaped_t r;
        r.kind = kind;
        r.data = data;
        r.code = code;
        r.last = 1'b0;
        beat_results.insert(beat_results.size(), r);
    endfunction

    function automatic void owe_error(input logic [2:0] code);
        parse_phase = jsu_pkg::PH_WAIT;
        owe(jsu_pkg::KIND_ERR, 8'h00, code);
    endfunction

    // UTF-8 bytes of a BMP code point; surrogates are not special
    function automatic void owe_utf8(input logic [15:0] cp);
        if (cp < jsu_pkg::CP_1B_LIMIT) begin
            owe(jsu_pkg::KIND_DATA, cp[7:0], jsu_pkg::ERR_NONE);
        end else if (cp < jsu_pkg::CP_2B_LIMIT) begin
            owe(jsu_pkg::KIND_DATA, jsu_pkg::UTF_LEAD2 | {3'b000, cp[10:6]},
                jsu_pkg::ERR_NONE);
            owe(jsu_pkg::KIND_DATA, jsu_pkg::UTF_CONT | {2'b00, cp[5:0]},
                jsu_pkg::ERR_NONE);
        end else begin
            owe(jsu_pkg::KIND_DATA, jsu_pkg::UTF_LEAD3 | {4'h0, cp[15:12]},
                jsu_pkg::ERR_NONE);
            owe(jsu_pkg::KIND_DATA, jsu_pkg::UTF_CONT | {2'b00, cp[11:6]},
                jsu_pkg::ERR_NONE);
            owe(jsu_pkg::KIND_DATA, jsu_pkg::UTF_CONT | {2'b00, cp[5:0]},
                jsu_pkg::ERR_NONE);
        end
    endfunction

    function automatic void decode_beat(input logic [7:0] ch, input logic eot);
        logic [4:0] nib;
        logic [8:0] esc;
        beat_results.delete();
        case (parse_phase)
            jsu_pkg::PH_BODY: begin
                if (eot) begin
                    owe_error(jsu_pkg::ERR_UNTERM);
                end else if (ch == jsu_pkg::CH_QUOTE) begin
                    parse_phase = jsu_pkg::PH_WAIT;
                    owe(jsu_pkg::KIND_DONE, 8'h00, jsu_pkg::ERR_NONE);
                end else if (ch == jsu_pkg::CH_BSLASH) begin
                    parse_phase = jsu_pkg::PH_ESC;
                end else if (ch < jsu_pkg::CH_SPACE) begin
                    owe_error(jsu_pkg::ERR_CTRL);
                end else begin
                    owe(jsu_pkg::KIND_DATA, ch, jsu_pkg::ERR_NONE);
                end
            end
            jsu_pkg::PH_ESC: begin
                esc = escape_target(ch);
                if (eot) begin
                    owe_error(jsu_pkg::ERR_END_ESC);
                end else if (ch == jsu_pkg::CH_U) begin
                    parse_phase = jsu_pkg::PH_HEX;
                    code_point  = 16'h0000;
                    hex_count   = 2'd0;
                end else if (!esc[8]) begin
                    owe_error(jsu_pkg::ERR_BAD_ESC);
                end else begin
                    parse_phase = jsu_pkg::PH_BODY;
                    owe(jsu_pkg::KIND_DATA, esc[7:0], jsu_pkg::ERR_NONE);
                end
            end
            jsu_pkg::PH_HEX: begin
                nib = nibble_of(ch);
                if (eot) begin
                    owe_error(jsu_pkg::ERR_END_HEX);
                end else if (!nib[4]) begin
                    // a bad digit still eats the rest of the four characters
                    if (hex_count == 2'd3) begin
                        owe_error(jsu_pkg::ERR_BAD_HEX);
                    end else begin
                        hex_count++;
                        parse_phase = jsu_pkg::PH_HEXBAD;
                    end
                end else begin
                    code_point = {code_point[11:0], nib[3:0]};
                    if (hex_count == 2'd3) begin
                        hex_count   = 2'd0;
                        parse_phase = jsu_pkg::PH_BODY;
                        owe_utf8(code_point);
                    end else begin
                        hex_count++;
                    end
                end
            end
            jsu_pkg::PH_HEXBAD: begin
                if (eot) owe_error(jsu_pkg::ERR_END_HEX);
                else if (hex_count == 2'd3) owe_error(jsu_pkg::ERR_BAD_HEX);
                else hex_count++;
            end
            default: begin
                // waiting for the opening quote; a stray phase behaves the same
                if (eot || ch != jsu_pkg::CH_QUOTE) owe_error(jsu_pkg::ERR_NO_OPEN);
                else parse_phase = jsu_pkg::PH_BODY;
            end
        endcase
        if (beat_results.size() > 0) beat_results[$].last = 1'b1;
        foreach (beat_results[i]) expected_results.insert(expected_results.size(), beat_results[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic void add_beat(input logic [7:0] ch, input logic eot);
        text_beat_t t;
        t.ch  = ch;
        t.eot = eot;
        pending_beats.insert(pending_beats.size(), t);
    endfunction

    // end of text; the byte lane carries junk the block must ignore
    function automatic void add_end();
        add_beat(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] ch;
        logic [4:0] nib;
        do begin
            ch  = 8'($urandom_range(0, 255));
            nib = nibble_of(ch);
        end while (nib[4]);
        return ch;
    endfunction

    // \uXXXX with digits of random case; bad_at >= 0 spoils that digit,
    // n_digits < 4 truncates the sequence
    function automatic void add_hex_escape(input logic [15:0] cp, input int bad_at,
                                           input int n_digits);
        add_beat(jsu_pkg::CH_BSLASH, 1'b0);
        add_beat(jsu_pkg::CH_U, 1'b0);
        for (int i = 0; i < n_digits; i++) begin
            if (i == bad_at) add_beat(pick_non_hex(), 1'b0);
            else add_beat(hex_char(cp[15 - 4*i -: 4], 1'($urandom_range(0, 1))), 1'b0);
        end
    endfunction

    function automatic logic [15:0] pick_code_point();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 16'h7F));
            1:       return 16'($urandom_range(16'h80, 16'h7FF));
            2:       return 16'($urandom_range(16'hD800, 16'hDFFF));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic void add_body_char();
        logic [7:0] ch;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                // ASCII 0x20 to 0x7F other than quote and backslash
                do ch = 8'($urandom_range(8'h20, 8'h7F));
                while (ch == jsu_pkg::CH_QUOTE || ch == jsu_pkg::CH_BSLASH);
                add_beat(ch, 1'b0);
            end
            4: add_beat(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
            5, 6: begin
                add_beat(jsu_pkg::CH_BSLASH, 1'b0);
                add_beat(ESC_LETTERS[$urandom_range(0, 7)], 1'b0);
            end
            default: add_hex_escape(pick_code_point(), -1, 4);
        endcase
    endfunction

    // a way for a string to go wrong
    function automatic void add_broken_tail();
        logic [7:0] ch;
        logic [8:0] esc;
        case ($urandom_range(0, 5))
            0: add_beat(8'($urandom_range(0, 8'h1F)), 1'b0);         // control byte
            1: begin                                                 // unknown escape
                do begin
                    ch  = 8'($urandom_range(0, 255));
                    esc = escape_target(ch);
                end while (esc[8] || ch == jsu_pkg::CH_U);
                add_beat(jsu_pkg::CH_BSLASH, 1'b0);
                add_beat(ch, 1'b0);
            end
            2: add_end();                                            // unterminated
            3: begin                                                 // end after backslash
                add_beat(jsu_pkg::CH_BSLASH, 1'b0);
                add_end();
            end
            4: begin                                                 // end inside \u
                add_hex_escape(pick_code_point(),
                               $urandom_range(0, 1) ? $urandom_range(0, 3) : -1,
                               $urandom_range(0, 3));
                add_end();
            end
            default: add_hex_escape(pick_code_point(), $urandom_range(0, 3), 4);
        endcase
    endfunction

    function automatic void add_random_text();
        logic [7:0] ch;
        int         n_chars;
        if ($urandom_range(0, 9) == 0) begin
            // noise while waiting for a quote
            if ($urandom_range(0, 3) == 0) begin
                add_end();
            end else begin
                do ch = 8'($urandom_range(0, 255)); while (ch == jsu_pkg::CH_QUOTE);
                add_beat(ch, 1'b0);
            end
        end else begin
            n_chars = $urandom_range(0, 8);
            add_beat(jsu_pkg::CH_QUOTE, 1'b0);
            for (int i = 0; i < n_chars; i++) add_body_char();
            if ($urandom_range(0, 9) < 7) add_beat(jsu_pkg::CH_QUOTE, 1'b0);
            else add_broken_tail();
        end
    endfunction

    function automatic logic in_final_stretch();
        return pending_beats.size() < FINAL_STRETCH;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents text beats on falling edges, with random gaps
    // ------------------------------------------------------------------
    logic       beat_taken = 1'b0;  // set by the monitor when s_valid/s_ready met
    int         send_gap   = 0;
    text_beat_t next_beat;

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || beat_taken)) begin
            beat_taken = 1'b0;
            if (send_gap == 0 && !in_final_stretch() && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 16);
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                next_beat = pending_beats.pop_front();
                s_valid       <= 1'b1;
                s_in_byte     <= next_beat.ch;
                s_end_of_text <= next_beat.eot;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: drops m_ready in random bursts of stalls
    int hold_left = 0;

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (aresetn && !in_final_stretch() && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 16) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted text beat, checks each result beat
    // ------------------------------------------------------------------
    unescaped_t want;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_beat(s_in_byte, s_end_of_text);
                beat_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing owed: kind %0d byte %02h code %0d",
                           m_out_kind, m_out_byte, m_error_code);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_out_kind !== want.kind) begin
                        $error("m_out_kind: expected %0d, got %0d", want.kind, m_out_kind);
                        fail_count++;
                    end
                    if (m_out_byte !== want.data) begin
                        $error("m_out_byte: expected %02h, got %02h", want.data, m_out_byte);
                        fail_count++;
                    end
                    if (m_error_code !== want.code) begin
                        $error("m_error_code: expected %0d, got %0d",
                               want.code, m_error_code);
                        fail_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("m_last: expected %0d, got %0d", want.last, m_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed text, random text, reset, drain, verdict
    // ------------------------------------------------------------------
    int directed_beats;

    initial begin
        // waiting state: stray byte, then end of text
        add_beat(8'h78, 1'b0);
        add_end();
        // surrogate encoded straight to three bytes, then a bad first digit
        // followed by a quote that the \u sequence must swallow
        add_beat(jsu_pkg::CH_QUOTE, 1'b0);
        add_hex_escape(16'hD800, -1, 4);
        add_beat(jsu_pkg::CH_BSLASH, 1'b0);
        add_beat(jsu_pkg::CH_U, 1'b0);
        add_beat(8'h67, 1'b0);
        add_beat(jsu_pkg::CH_QUOTE, 1'b0);
        add_beat(8'h31, 1'b0);
        add_beat(8'h32, 1'b0);
        // control byte in the body
        add_beat(jsu_pkg::CH_QUOTE, 1'b0);
        add_beat(8'h1F, 1'b0);
        // end of text right after a backslash
        add_beat(jsu_pkg::CH_QUOTE, 1'b0);
        add_beat(jsu_pkg::CH_BSLASH, 1'b0);
        add_end();
        // end of text in the body
        add_beat(jsu_pkg::CH_QUOTE, 1'b0);
        add_end();
        // end of text inside \u
        add_beat(jsu_pkg::CH_QUOTE, 1'b0);
        add_beat(jsu_pkg::CH_BSLASH, 1'b0);
        add_beat(jsu_pkg::CH_U, 1'b0);
        add_beat(8'h41, 1'b0);
        add_end();
        directed_beats = pending_beats.size();

        while (pending_beats.size() - directed_beats < RANDOM_BEATS) add_random_text();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all text sent and all owed results seen
        do @(negedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
